[rtl/core/lc3ie_pkg.sv]
// Shared types and constants for the LC-3 instruction execute block.
package lc3ie_pkg;

  localparam int MEM_AW    = 16;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam int RF_AW    = 3;
  localparam int RF_DEPTH = 1 << RF_AW;
  localparam int RF_PORTS = 2;

  localparam logic [15:0]      START_PC_RST = 16'h3000;
  localparam logic [RF_AW-1:0] LINK_REG     = 3'd7;

  localparam logic [2:0] FLAG_N = 3'b100;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_P = 3'b001;

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SETPC = 2'd2
  } item_op_e;

  typedef enum logic [3:0] {
    I_BR   = 4'h0,
    I_ADD  = 4'h1,
    I_LD   = 4'h2,
    I_ST   = 4'h3,
    I_JSR  = 4'h4,
    I_AND  = 4'h5,
    I_LDR  = 4'h6,
    I_STR  = 4'h7,
    I_RTI  = 4'h8,
    I_NOT  = 4'h9,
    I_LDI  = 4'hA,
    I_STI  = 4'hB,
    I_JMP  = 4'hC,
    I_RSV  = 4'hD,
    I_LEA  = 4'hE,
    I_TRAP = 4'hF
  } isa_op_e;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [15:0]      data;
  } reg_wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic [15:0]      pc;
    logic [2:0]       cond;
    logic             reg_written;
    logic [RF_AW-1:0] reg_index;
    logic [15:0]      reg_value;
    logic             mem_written;
    logic [15:0]      mem_address;
    logic [15:0]      mem_value;
  } res_t;

endpackage

[rtl/core/lc3ie_intf.sv]
// Item and result channel interfaces of the LC-3 instruction execute block.
interface lc3ie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] instruction;
  logic [15:0] address;
  logic [15:0] data;

  modport source (output valid, opcode, instruction, address, data, input ready);
  modport sink   (input valid, opcode, instruction, address, data, output ready);
endinterface

interface lc3ie_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [2:0]  cond;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic        mem_written;
  logic [15:0] mem_address;
  logic [15:0] mem_value;

  modport source (output valid, pc, cond, reg_written, reg_index, reg_value, mem_written,
                  mem_address, mem_value, input ready);
  modport sink   (input valid, pc, cond, reg_written, reg_index, reg_value, mem_written,
                  mem_address, mem_value, output ready);
endinterface

[rtl/core/lc3ie_regfile.sv]
// Eight-entry general register file, two registered read ports with write bypass.
module lc3ie_regfile (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  lc3ie_pkg::reg_wr_t                        wr_i,
  input  logic                                      rd_en_i,
  input  logic [lc3ie_pkg::RF_PORTS-1:0][lc3ie_pkg::RF_AW-1:0] rd_addr_i,
  output logic [lc3ie_pkg::RF_PORTS-1:0][15:0]      rd_data_o
);
  import lc3ie_pkg::*;

  logic [15:0]                mem_q [RF_DEPTH];
  logic [RF_DEPTH-1:0]        vld_q;
  logic [RF_PORTS-1:0][15:0]  ram_q;
  logic [RF_PORTS-1:0][15:0]  byp_q;
  logic [RF_PORTS-1:0]        use_byp_q;
  logic [RF_PORTS-1:0]        use_ram_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      for (int p = 0; p < RF_PORTS; p++) begin
        ram_q[p] <= mem_q[rd_addr_i[p]];
        byp_q[p] <= wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      use_byp_q <= '0;
      use_ram_q <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        for (int p = 0; p < RF_PORTS; p++) begin
          use_byp_q[p] <= wr_i.en && (wr_i.addr == rd_addr_i[p]);
          use_ram_q[p] <= vld_q[rd_addr_i[p]];
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < RF_PORTS; p++) begin
      if (use_byp_q[p]) begin
        rd_data_o[p] = byp_q[p];
      end else if (use_ram_q[p]) begin
        rd_data_o[p] = ram_q[p];
      end else begin
        rd_data_o[p] = '0;
      end
    end
  end

endmodule

[rtl/core/lc3ie_wordmem.sv]
// Word memory with one write port, one registered read port and a clearing sweep after reset.
module lc3ie_wordmem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lc3ie_pkg::mem_wr_t wr_i,
  input  lc3ie_pkg::mem_rd_t rd_i,
  output logic [15:0]        rd_data_o,
  output logic               busy_o
);
  import lc3ie_pkg::*;

  logic [15:0]       mem_q [MEM_DEPTH];
  logic [15:0]       rd_q;
  logic [MEM_AW-1:0] clr_addr_q;
  logic              clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_busy_q;

endmodule

[rtl/core/lc3_instruction_execute.sv]
// LC-3 instruction execute block: sequencer, PC and flags around register file and word memory.
//
//  channel   | dir | handshake          | payload
//  item_i    | in  | valid / ready      | opcode, instruction, address, data
//  result_o  | out | valid / ready      | pc, cond, reg_written/index/value, mem_written/address/value
//  cfg       | in  | cfg_we_i (no wait) | cfg_wdata_i: start_pc
//
//  One transaction in, one result out. ALU, LEA, ST, STR, jumps and branches finish in step S_X1;
//  LD, LDR and STI go on to S_X2, LDI on to S_X3: each word memory read takes a step on its single read port.
//  A new transaction is taken in the cycle the previous one completes.
//  After reset a sweep zeroes the word memory, with ready low until the sweep is done.
//  Results wait in an output register; a stalled result holds the final step only.
module lc3_instruction_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  lc3ie_in_if.sink    item_i,
  lc3ie_out_if.source result_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import lc3ie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_X1   = 4'b0010,
    S_X2   = 4'b0100,
    S_X3   = 4'b1000
  } step_e;

  function automatic logic [2:0] flags_of(logic [15:0] v);
    logic [2:0] f;
    if (v == '0) begin
      f = FLAG_Z;
    end else if (v[15]) begin
      f = FLAG_N;
    end else begin
      f = FLAG_P;
    end
    return f;
  endfunction

  step_e       state_q, state_d;
  item_op_e    x_op_q;
  logic [15:0] x_ins_q;
  logic [15:0] x_addr_q;
  logic [15:0] x_data_q;
  logic [15:0] pc_q, pc_d;
  logic [2:0]  flags_q, flags_d;
  logic        out_vld_q;
  res_t        res_q, res_d;

  logic        acc, out_free, last, done, fin, mem_busy;
  isa_op_e     in_isa, x_isa;
  logic [RF_PORTS-1:0][RF_AW-1:0] rf_rd_addr;
  logic [RF_PORTS-1:0][15:0]      rf_rd_data;
  logic [15:0] rf_a, rf_b, mem_rd;
  reg_wr_t     rf_wr;
  mem_wr_t     mem_wr;
  mem_rd_t     mem_rd_req;

  logic [15:0] pc_inc, off9, off6, off11, imm5, pc_rel, base_rel, opb;
  logic [RF_AW-1:0] dr;
  logic              rw, mw;
  logic [RF_AW-1:0]  ri;
  logic [15:0]       rv, mv;
  logic [MEM_AW-1:0] ma;

  assign out_free     = !out_vld_q || result_o.ready;
  assign item_i.ready = !mem_busy && ((state_q == S_IDLE) || fin);
  assign acc          = item_i.valid && item_i.ready;

  assign in_isa = isa_op_e'(item_i.instruction[15:12]);
  always_comb begin
    rf_rd_addr[0] = item_i.instruction[8:6];
    if (in_isa inside {I_ST, I_STI, I_STR}) begin
      rf_rd_addr[1] = item_i.instruction[11:9];
    end else begin
      rf_rd_addr[1] = item_i.instruction[2:0];
    end
  end

  lc3ie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rf_wr),
    .rd_en_i   (acc),
    .rd_addr_i (rf_rd_addr),
    .rd_data_o (rf_rd_data)
  );

  lc3ie_wordmem u_wordmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd_req),
    .rd_data_o (mem_rd),
    .busy_o    (mem_busy)
  );

  assign rf_a     = rf_rd_data[0];
  assign rf_b     = rf_rd_data[1];
  assign x_isa    = isa_op_e'(x_ins_q[15:12]);
  assign dr       = x_ins_q[11:9];
  assign pc_inc   = pc_q + 16'd1;
  assign off9     = {{7{x_ins_q[8]}}, x_ins_q[8:0]};
  assign off6     = {{10{x_ins_q[5]}}, x_ins_q[5:0]};
  assign off11    = {{5{x_ins_q[10]}}, x_ins_q[10:0]};
  assign imm5     = {{11{x_ins_q[4]}}, x_ins_q[4:0]};
  assign pc_rel   = pc_inc + off9;
  assign base_rel = rf_a + off6;
  assign opb      = x_ins_q[5] ? imm5 : rf_b;

  always_comb begin
    state_d    = state_q;
    last       = 1'b1;
    pc_d       = pc_q;
    mem_rd_req = '0;
    rw         = 1'b0;
    ri         = '0;
    rv         = '0;
    mw         = 1'b0;
    ma         = '0;
    mv         = '0;
    case (state_q)
      S_X1: begin
        case (x_op_q)
          OP_EXEC: begin
            pc_d = pc_inc;
            case (x_isa)
              I_ADD: begin
                rw = 1'b1; ri = dr; rv = rf_a + opb;
              end
              I_AND: begin
                rw = 1'b1; ri = dr; rv = rf_a & opb;
              end
              I_NOT: begin
                rw = 1'b1; ri = dr; rv = ~rf_a;
              end
              I_LEA: begin
                rw = 1'b1; ri = dr; rv = pc_rel;
              end
              I_LD, I_LDI, I_STI: begin
                last            = 1'b0;
                state_d         = S_X2;
                mem_rd_req.en   = 1'b1;
                mem_rd_req.addr = pc_rel[MEM_AW-1:0];
              end
              I_LDR: begin
                last            = 1'b0;
                state_d         = S_X2;
                mem_rd_req.en   = 1'b1;
                mem_rd_req.addr = base_rel[MEM_AW-1:0];
              end
              I_ST: begin
                mw = 1'b1; ma = pc_rel[MEM_AW-1:0]; mv = rf_b;
              end
              I_STR: begin
                mw = 1'b1; ma = base_rel[MEM_AW-1:0]; mv = rf_b;
              end
              I_JMP: begin
                pc_d = rf_a;
              end
              I_JSR: begin
                rw   = 1'b1; ri = LINK_REG; rv = pc_inc;
                pc_d = x_ins_q[11] ? (pc_inc + off11) : rf_a;
              end
              I_BR: begin
                if ((dr & flags_q) != '0) begin
                  pc_d = pc_rel;
                end
              end
              default: ;
            endcase
          end
          OP_LOAD: begin
            mw = 1'b1; ma = x_addr_q[MEM_AW-1:0]; mv = x_data_q;
          end
          OP_SETPC: begin
            pc_d = x_addr_q;
          end
          default: ;
        endcase
      end
      S_X2: begin
        case (x_isa)
          I_LDI: begin
            last            = 1'b0;
            state_d         = S_X3;
            mem_rd_req.en   = 1'b1;
            mem_rd_req.addr = mem_rd[MEM_AW-1:0];
          end
          I_STI: begin
            mw = 1'b1; ma = mem_rd[MEM_AW-1:0]; mv = rf_b;
          end
          default: begin
            rw = 1'b1; ri = dr; rv = mem_rd;
          end
        endcase
      end
      S_X3: begin
        rw = 1'b1; ri = dr; rv = mem_rd;
      end
      default: ;
    endcase
    if (last) begin
      state_d = S_IDLE;
    end
  end

  assign done    = (state_q != S_IDLE) && (!last || out_free);
  assign fin     = done && last;
  assign flags_d = (rw && (x_isa != I_JSR)) ? flags_of(rv) : flags_q;

  assign rf_wr.en    = rw && fin;
  assign rf_wr.addr  = ri;
  assign rf_wr.data  = rv;
  assign mem_wr.en   = mw && fin;
  assign mem_wr.addr = ma;
  assign mem_wr.data = mv;

  always_comb begin
    res_d.pc          = pc_d;
    res_d.cond        = flags_d;
    res_d.reg_written = rw;
    res_d.reg_index   = ri;
    res_d.reg_value   = rv;
    res_d.mem_written = mw;
    res_d.mem_address = 16'(ma);
    res_d.mem_value   = mv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= START_PC_RST;
      flags_q   <= FLAG_Z;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        state_q <= S_X1;
      end else if (done) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end else if (done) begin
        pc_q <= pc_d;
      end
      if (fin) begin
        flags_q <= flags_d;
      end
      if (fin) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_op_q   <= item_op_e'(item_i.opcode);
      x_ins_q  <= item_i.instruction;
      x_addr_q <= item_i.address;
      x_data_q <= item_i.data;
    end
    if (fin) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.pc          = res_q.pc;
  assign result_o.cond        = res_q.cond;
  assign result_o.reg_written = res_q.reg_written;
  assign result_o.reg_index   = res_q.reg_index;
  assign result_o.reg_value   = res_q.reg_value;
  assign result_o.mem_written = res_q.mem_written;
  assign result_o.mem_address = res_q.mem_address;
  assign result_o.mem_value   = res_q.mem_value;

endmodule

[rtl/core/lc3ie_checker.sv]
// Port-level checks of the LC-3 instruction execute block, bound to the top level.
module lc3ie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_pc_i,
  input logic [2:0]  out_cond_i,
  input logic        out_reg_written_i,
  input logic [2:0]  out_reg_index_i,
  input logic [15:0] out_reg_value_i,
  input logic        out_mem_written_i,
  input logic [15:0] out_mem_address_i,
  input logic [15:0] out_mem_value_i
);

  // a stalled result stays valid and holds pc, cond, reg_value, mem_address and mem_value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pc_i) && $stable(out_cond_i)
      && $stable(out_reg_value_i) && $stable(out_mem_address_i) && $stable(out_mem_value_i))
    else $error("stalled result changed");

  a_clear_blocks: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("transaction taken during memory clearing");

  a_cond_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot(out_cond_i))
    else $error("condition flags not one-hot");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_reg_written_i && out_mem_written_i))
    else $error("register and memory written by one transaction");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_reg_written_i || (out_reg_index_i == '0 && out_reg_value_i == '0))
      && (out_mem_written_i || (out_mem_address_i == '0 && out_mem_value_i == '0)))
    else $error("unused result fields not zero");

endmodule

bind lc3_instruction_execute lc3ie_checker u_lc3ie_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (item_i.valid),
  .in_ready_i        (item_i.ready),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .out_pc_i          (result_o.pc),
  .out_cond_i        (result_o.cond),
  .out_reg_written_i (result_o.reg_written),
  .out_reg_index_i   (result_o.reg_index),
  .out_reg_value_i   (result_o.reg_value),
  .out_mem_written_i (result_o.mem_written),
  .out_mem_address_i (result_o.mem_address),
  .out_mem_value_i   (result_o.mem_value)
);
